### src/padsr_pkg.sv
// Shared types and constants for the polyphonic envelope generator.
package padsr_pkg;

  localparam int LVL_W  = 17;
  localparam int TIME_W = 24;
  localparam int HOLD_W = 25;
  localparam int AGE_W  = 32;
  localparam int KNOB_W = 16;
  localparam int PLEN_W = 23;
  localparam int DIV_W  = 41;
  localparam logic [LVL_W-1:0] LEVEL_ONE = 17'h10000;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_GATE = 2'd1;
  localparam logic [1:0] ACT_TRIG = 2'd2;

  localparam logic [1:0] POL_RESET  = 2'd0;
  localparam logic [1:0] POL_LEGATO = 2'd1;
  localparam logic [1:0] POL_POLY   = 2'd2;

  localparam logic [1:0] MODE_DECAY = 2'd0;
  localparam logic [1:0] MODE_AD    = 2'd1;
  localparam logic [1:0] MODE_ADS   = 2'd2;
  localparam logic [1:0] MODE_FULL  = 2'd3;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_ATTACK  = 3'd1;
  localparam logic [2:0] REG_DECAY   = 3'd2;
  localparam logic [2:0] REG_SUSTAIN = 3'd3;
  localparam logic [2:0] REG_RELEASE = 3'd4;
  localparam logic [2:0] REG_VLIMIT  = 3'd5;
  localparam logic [2:0] REG_POLICY  = 3'd6;

  typedef enum logic [2:0] {
    PHASE_IDLE, PHASE_ATTACK, PHASE_DECAY, PHASE_SUSTAIN, PHASE_RELEASE
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LEN, ST_LENW, ST_ARM_SCAN, ST_ARM_DO, ST_TICK_RD, ST_TICK_DIV,
    ST_TICK_WAIT, ST_TICK_WR, ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic len_start;
    logic arm_clear;
    logic arm_scan;
    logic arm_do;
    logic gate_fall;
    logic tick_clear;
    logic tick_rd;
    logic div_start;
    logic tick_wr;
    logic voice_next;
  } cmd_t;

  typedef struct packed {
    logic len_done;
    logic scan_last;
    logic div_done;
    logic voice_last;
  } sts_t;

endpackage

### src/padsr_div.sv
// Shared restoring divider, one quotient bit per cycle.
module padsr_div
  import padsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [PLEN_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DIV_W + 1);
  logic [DIV_W-1:0]  q_r, q_nxt;
  logic [PLEN_W:0]   rem_r, rem_nxt;
  logic [PLEN_W-1:0] d_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PLEN_W+1:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, q_r[DIV_W-1]};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; cnt_nxt = CNT_W'(DIV_W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {2'b00, d_r}) begin
        rem_nxt = (PLEN_W+1)'(trial - {2'b00, d_r});
        q_nxt = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[PLEN_W:0];
        q_nxt = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (start) d_r <= divisor;
  end

  assign done = done_r;
  assign quotient = q_r;
endmodule

### src/padsr_ctrl.sv
// Controller state machine sequencing arming, phase-length setup and tick walks.
module padsr_ctrl
  import padsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [1:0] in_action,
  input  logic       in_level,
  input  logic       gate_last,
  input  logic       trig_last,
  input  logic       out_busy,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       in_ready,
  output logic       out_load
);
  ctrl_state_t state_r, state_nxt;
  logic        arm_r, arm_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; arm_r <= 1'b0;
    end else begin
      state_r <= state_nxt; arm_r <= arm_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r; arm_nxt = arm_r; cmd = '0; out_load = 1'b0;
    in_ready = (state_r == ST_IDLE) && !out_busy;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_TICK) begin
            cmd.len_start = 1'b1; arm_nxt = 1'b0; state_nxt = ST_LEN;
          end else if (in_action == ACT_GATE) begin
            if (in_level && !gate_last) begin
              cmd.len_start = 1'b1; arm_nxt = 1'b1; state_nxt = ST_LEN;
            end else if (!in_level && gate_last) begin
              cmd.gate_fall = 1'b1;
            end
          end else if (in_action == ACT_TRIG) begin
            if (in_level && !trig_last) begin
              cmd.len_start = 1'b1; arm_nxt = 1'b1; state_nxt = ST_LEN;
            end
          end
        end
      end
      ST_LEN: state_nxt = ST_LENW;
      ST_LENW: begin
        if (sts.len_done) begin
          if (arm_r) begin
            cmd.arm_clear = 1'b1; state_nxt = ST_ARM_SCAN;
          end else begin
            cmd.tick_clear = 1'b1; state_nxt = ST_TICK_RD;
          end
        end
      end
      ST_ARM_SCAN: begin
        cmd.arm_scan = 1'b1;
        if (sts.scan_last) state_nxt = ST_ARM_DO;
      end
      ST_ARM_DO: begin
        cmd.arm_do = 1'b1; state_nxt = ST_IDLE;
      end
      ST_TICK_RD: begin
        cmd.tick_rd = 1'b1; state_nxt = ST_TICK_DIV;
      end
      ST_TICK_DIV: begin
        cmd.div_start = 1'b1; state_nxt = ST_TICK_WAIT;
      end
      ST_TICK_WAIT: if (sts.div_done) state_nxt = ST_TICK_WR;
      ST_TICK_WR: begin
        cmd.tick_wr = 1'b1;
        if (sts.voice_last) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.voice_next = 1'b1; state_nxt = ST_TICK_RD;
        end
      end
      ST_OUT: begin
        out_load = 1'b1; state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

### src/padsr_dp.sv
// Datapath: voice state, phase lengths, ramp evaluation and level maximum.
module padsr_dp
  import padsr_pkg::*;
#(
  parameter int NV = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              in_fire,
  input  logic [1:0]        in_action,
  input  logic              in_level,
  input  logic [19:0]       in_dt,
  input  logic [1:0]        env_mode,
  input  logic [KNOB_W-1:0] attack_knob,
  input  logic [KNOB_W-1:0] decay_knob,
  input  logic [LVL_W-1:0]  sustain_level,
  input  logic [KNOB_W-1:0] release_knob,
  input  logic [4:0]        voice_limit,
  input  logic [1:0]        retrig_policy,
  output logic              gate_last,
  output logic              trig_last,
  output logic [LVL_W-1:0]  best
);
  localparam int VI_W = (NV > 1) ? $clog2(NV) : 1;
  localparam int VC_W = $clog2(NV + 1);

  phase_t            ph_r   [NV];
  logic              act_r  [NV];
  logic              held_r [NV];
  logic [TIME_W-1:0] tm_r   [NV];
  logic [HOLD_W-1:0] hold_r [NV];
  logic [LVL_W-1:0]  lvl_r  [NV];
  logic [LVL_W-1:0]  rs_r   [NV];
  logic [LVL_W-1:0]  as_r   [NV];
  logic [AGE_W-1:0]  age_r  [NV];
  logic [AGE_W-1:0]  stamp_r;
  logic              gate_last_r, trig_last_r, gate_ok_r, momentary_r;
  logic [VI_W-1:0]   gated_r;
  logic [19:0]       dt_r;

  logic [1:0]        lsel_r;
  logic [KNOB_W-1:0] kmul_r;
  logic [31:0]       ksq_r;
  logic [53:0]       kprod_r;
  logic [2:0]        lcnt_r;
  logic [PLEN_W-1:0] au_r, du_r, ru_r;
  logic [LVL_W-1:0]  sus_lv;

  logic [VI_W-1:0]   scan_r, free_r, old_r;
  logic              found_r;
  logic [VC_W-1:0]   lim;

  logic [VI_W-1:0]   vi_r;
  logic [TIME_W-1:0] t_r;
  logic [LVL_W-1:0]  span_r, base_r;
  logic [PLEN_W-1:0] plen_r;
  logic              dsub_r;
  logic [1:0]        kind_r;
  logic [LVL_W-1:0]  best_r;
  logic              div_done;
  logic [DIV_W-1:0]  quot;
  logic [DIV_W-1:0]  prod;

  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_RAMP = 2'd1;

  assign lim = (voice_limit == 5'd0) ? VC_W'(1) :
               ({27'd0, voice_limit} > 32'(NV)) ? VC_W'(NV) : VC_W'(voice_limit);

  // phase length: 3000 + round(4e6 * k^2 / 2^32), computed in turn for attack, decay and release
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r <= '0;
    end else if (cmd.len_start) begin
      lcnt_r <= 3'd1; lsel_r <= 2'd0; kmul_r <= attack_knob;
    end else if (lcnt_r != 3'd0) begin
      case (lcnt_r)
        3'd1: begin ksq_r <= kmul_r * kmul_r; lcnt_r <= 3'd2; end
        3'd2: begin kprod_r <= 54'(ksq_r) * 54'd4000000; lcnt_r <= 3'd3; end
        3'd3: begin
          case (lsel_r)
            2'd0: au_r <= PLEN_W'(23'd3000 + 23'((kprod_r + 54'h80000000) >> 32));
            2'd1: du_r <= PLEN_W'(23'd3000 + 23'((kprod_r + 54'h80000000) >> 32));
            default: ru_r <= PLEN_W'(23'd3000 + 23'((kprod_r + 54'h80000000) >> 32));
          endcase
          if (lsel_r == 2'd2) begin
            lcnt_r <= 3'd0;
          end else begin
            lsel_r <= lsel_r + 2'd1;
            kmul_r <= (lsel_r == 2'd0) ? decay_knob : release_knob;
            lcnt_r <= 3'd1;
          end
        end
        default: lcnt_r <= 3'd0;
      endcase
    end
  end
  assign sts.len_done = (lcnt_r == 3'd0);

  always_comb begin
    if (env_mode < MODE_ADS) sus_lv = '0;
    else sus_lv = (sustain_level > LEVEL_ONE) ? LEVEL_ONE : sustain_level;
  end

  logic [PLEN_W-1:0] au_eff, ru_eff;
  logic [HOLD_W-1:0] mom_len;
  assign au_eff = (env_mode != MODE_DECAY) ? au_r : '0;
  assign ru_eff = (env_mode == MODE_FULL) ? ru_r : du_r;
  assign mom_len = HOLD_W'(au_eff) + HOLD_W'(du_r);

  assign sts.scan_last = ({1'b0, scan_r} == VC_W'(lim - 1'b1)) || (found_r && 1'b0);

  // ramp product for the current voice, formed combinationally from the registered span and time
  assign prod = DIV_W'(span_r) * DIV_W'(t_r);

  padsr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(prod),
    .divisor(plen_r), .done(div_done), .quotient(quot)
  );
  assign sts.div_done = div_done;
  assign sts.voice_last = ({1'b0, vi_r} == VC_W'(NV - 1));

  logic [VI_W-1:0] arm_i;
  logic            pol_poly, pol_leg;
  assign pol_poly = (retrig_policy == POL_POLY);
  assign pol_leg  = (retrig_policy == POL_LEGATO);
  assign arm_i = pol_poly ? (found_r ? free_r : old_r) : '0;

  logic [TIME_W:0]    tsum;
  logic [TIME_W-1:0]  tn;
  logic [HOLD_W:0]    hdec;
  logic [LVL_W-1:0]   wr_lvl;
  logic [LVL_W-1:0]   q_lvl;
  assign tsum = {1'b0, tm_r[vi_r]} + (TIME_W+1)'(dt_r);
  assign tn = tsum[TIME_W] ? {TIME_W{1'b1}} : tsum[TIME_W-1:0];
  assign hdec = {hold_r[vi_r][HOLD_W-1], hold_r[vi_r]} - (HOLD_W+1)'(dt_r);
  assign q_lvl = LVL_W'(quot);
  assign wr_lvl = dsub_r ? LVL_W'(base_r - q_lvl) : LVL_W'(base_r + q_lvl);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NV; i++) begin
        ph_r[i] <= PHASE_IDLE; act_r[i] <= 1'b0; held_r[i] <= 1'b0; tm_r[i] <= '0;
        hold_r[i] <= '1; lvl_r[i] <= '0; rs_r[i] <= '0; as_r[i] <= '0; age_r[i] <= '0;
      end
      stamp_r <= '0; gate_last_r <= 1'b0; trig_last_r <= 1'b0; gate_ok_r <= 1'b0;
      gated_r <= '0; best_r <= '0; vi_r <= '0; scan_r <= '0; found_r <= 1'b0;
      old_r <= '0; free_r <= '0; momentary_r <= 1'b0; dt_r <= '0;
    end else begin
      if (in_fire && in_action == ACT_TICK) dt_r <= in_dt;
      if (in_fire && in_action == ACT_GATE) begin
        gate_last_r <= in_level; momentary_r <= 1'b0;
      end
      if (in_fire && in_action == ACT_TRIG) begin
        trig_last_r <= in_level; momentary_r <= 1'b1;
      end
      if (cmd.gate_fall) begin
        if (gate_ok_r) held_r[gated_r] <= 1'b0;
        gate_ok_r <= 1'b0;
      end
      if (cmd.arm_clear) begin
        scan_r <= '0; found_r <= 1'b0; old_r <= '0;
      end
      if (cmd.arm_scan) begin
        if (!found_r && !act_r[scan_r]) begin
          found_r <= 1'b1; free_r <= scan_r;
        end
        if (age_r[scan_r] < age_r[old_r]) old_r <= scan_r;
        if (!sts.scan_last) scan_r <= scan_r + 1'b1;
      end
      if (cmd.arm_do) begin
        if (pol_leg && act_r[0] && ph_r[0] != PHASE_RELEASE) begin
          stamp_r <= stamp_r + 1'b1; age_r[0] <= stamp_r + 1'b1;
        end else begin
          act_r[arm_i] <= 1'b1; ph_r[arm_i] <= PHASE_ATTACK; tm_r[arm_i] <= '0;
          as_r[arm_i] <= (pol_leg && act_r[0]) ? lvl_r[0] : '0;
          lvl_r[arm_i] <= (pol_leg && act_r[0]) ? lvl_r[0] : '0;
          stamp_r <= stamp_r + 1'b1; age_r[arm_i] <= stamp_r + 1'b1;
        end
        held_r[arm_i] <= 1'b1;
        hold_r[arm_i] <= momentary_r ? mom_len : '1;
        if (!momentary_r) begin
          gated_r <= arm_i; gate_ok_r <= 1'b1;
        end
      end
      if (cmd.tick_clear) begin
        vi_r <= '0; best_r <= '0;
      end
      if (cmd.tick_rd) begin
        t_r <= tn; kind_r <= K_NONE; span_r <= '0; plen_r <= PLEN_W'(1); dsub_r <= 1'b0;
        base_r <= lvl_r[vi_r];
        if (act_r[vi_r]) begin
          tm_r[vi_r] <= tn;
          case (ph_r[vi_r])
            PHASE_ATTACK: if (held_r[vi_r] && au_eff != '0 && {9'd0, tn} < 33'(au_eff)) begin
              kind_r <= K_RAMP; span_r <= LVL_W'(LEVEL_ONE - as_r[vi_r]);
              base_r <= as_r[vi_r]; plen_r <= au_eff;
            end
            PHASE_DECAY: if (held_r[vi_r] && {9'd0, tn} < 33'(du_r)) begin
              kind_r <= K_RAMP; span_r <= LVL_W'(LEVEL_ONE - sus_lv);
              base_r <= LEVEL_ONE; plen_r <= du_r; dsub_r <= 1'b1;
            end
            PHASE_RELEASE: if ({9'd0, tn} < 33'(ru_eff)) begin
              kind_r <= K_RAMP; span_r <= rs_r[vi_r];
              base_r <= rs_r[vi_r]; plen_r <= ru_eff; dsub_r <= 1'b1;
            end
            default: kind_r <= K_NONE;
          endcase
        end
      end
      if (cmd.tick_wr) begin
        if (act_r[vi_r]) begin
          logic [LVL_W-1:0] nl;
          logic             na;
          nl = lvl_r[vi_r]; na = 1'b1;
          case (ph_r[vi_r])
            PHASE_ATTACK: begin
              if (!held_r[vi_r]) begin
                ph_r[vi_r] <= PHASE_RELEASE; tm_r[vi_r] <= '0; rs_r[vi_r] <= nl;
              end else if (kind_r == K_RAMP) begin
                nl = wr_lvl;
              end else begin
                nl = LEVEL_ONE; ph_r[vi_r] <= PHASE_DECAY; tm_r[vi_r] <= '0;
              end
            end
            PHASE_DECAY: begin
              if (!held_r[vi_r]) begin
                ph_r[vi_r] <= PHASE_RELEASE; tm_r[vi_r] <= '0; rs_r[vi_r] <= nl;
              end else if (kind_r == K_RAMP) begin
                nl = wr_lvl;
              end else begin
                nl = sus_lv; ph_r[vi_r] <= PHASE_SUSTAIN; tm_r[vi_r] <= '0;
              end
            end
            PHASE_SUSTAIN: begin
              nl = sus_lv;
              if (!held_r[vi_r]) begin
                ph_r[vi_r] <= PHASE_RELEASE; tm_r[vi_r] <= '0; rs_r[vi_r] <= sus_lv;
              end
            end
            PHASE_RELEASE: begin
              if (kind_r == K_RAMP) begin
                nl = wr_lvl;
              end else begin
                nl = '0; na = 1'b0; ph_r[vi_r] <= PHASE_IDLE; tm_r[vi_r] <= '0;
              end
            end
            default: nl = lvl_r[vi_r];
          endcase
          lvl_r[vi_r] <= nl; act_r[vi_r] <= na;
          if (!hold_r[vi_r][HOLD_W-1] && hold_r[vi_r] != '0) begin
            if (hdec[HOLD_W] || hdec[HOLD_W-1:0] == '0) begin
              held_r[vi_r] <= 1'b0; hold_r[vi_r] <= '1;
            end else begin
              hold_r[vi_r] <= hdec[HOLD_W-1:0];
            end
          end
          if (na && nl > best_r) best_r <= nl;
        end
        if (cmd.voice_next) vi_r <= vi_r + 1'b1;
      end
    end
  end

  assign gate_last = gate_last_r;
  assign trig_last = trig_last_r;
  assign best = (best_r > LEVEL_ONE) ? LEVEL_ONE : best_r;
endmodule

### src/poly_adsr_envelope.sv
// Polyphonic ADSR envelope generator top level with register port.
// A gate or trigger request that arms no voice completes in the cycle it is
// accepted; one that arms a voice recomputes the phase lengths on a shared
// multiplier, then scans voices up to the clamped voice limit. A tick request
// also recomputes the phase lengths, then walks every voice through one
// shared bit-serial divider before its result is offered. One result per
// tick.
module poly_adsr_envelope
  import padsr_pkg::*;
#(
  parameter int MAX_VOICES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // action[1:0], level[2], elapsed_us[22:3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // envelope_out[16:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [1:0]        mode_r, policy_r;
  logic [KNOB_W-1:0] atk_r, dec_r, rel_r;
  logic [LVL_W-1:0]  sus_r;
  logic [4:0]        lim_r;
  logic [2:0]        ridx;
  logic              wr;
  cmd_t              cmd;
  sts_t              sts;
  logic              in_fire, out_load, gate_last, trig_last;
  logic [LVL_W-1:0]  best;
  logic              ov_r;
  logic [LVL_W-1:0]  od_r;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0; atk_r <= 16'd3277; dec_r <= 16'd19661; sus_r <= 17'd32768;
      rel_r <= 16'd19661; lim_r <= 5'd1; policy_r <= '0;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      case (ridx)
        REG_MODE:    mode_r <= cfg_pwdata[1:0];
        REG_ATTACK:  atk_r <= cfg_pwdata[15:0];
        REG_DECAY:   dec_r <= cfg_pwdata[15:0];
        REG_SUSTAIN: sus_r <= cfg_pwdata[16:0];
        REG_RELEASE: rel_r <= cfg_pwdata[15:0];
        REG_VLIMIT:  lim_r <= cfg_pwdata[4:0];
        REG_POLICY:  policy_r <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_MODE:    cfg_prdata = {30'd0, mode_r};
      REG_ATTACK:  cfg_prdata = {16'd0, atk_r};
      REG_DECAY:   cfg_prdata = {16'd0, dec_r};
      REG_SUSTAIN: cfg_prdata = {15'd0, sus_r};
      REG_RELEASE: cfg_prdata = {16'd0, rel_r};
      REG_VLIMIT:  cfg_prdata = {27'd0, lim_r};
      REG_POLICY:  cfg_prdata = {30'd0, policy_r};
      default:     cfg_prdata = '0;
    endcase
  end

  assign in_fire = in_tvalid && in_tready;

  padsr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_action(in_tdata[1:0]),
    .in_level(in_tdata[2]), .gate_last(gate_last), .trig_last(trig_last),
    .out_busy(ov_r && !out_tready), .sts(sts), .cmd(cmd), .in_ready(in_tready),
    .out_load(out_load)
  );

  padsr_dp #(.NV(MAX_VOICES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_fire(in_fire),
    .in_action(in_tdata[1:0]), .in_level(in_tdata[2]), .in_dt(in_tdata[22:3]),
    .env_mode(mode_r), .attack_knob(atk_r), .decay_knob(dec_r),
    .sustain_level(sus_r), .release_knob(rel_r), .voice_limit(lim_r),
    .retrig_policy(policy_r), .gate_last(gate_last), .trig_last(trig_last),
    .best(best)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_load) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
    if (out_load) od_r <= best;
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {7'd0, od_r};
endmodule
